// ===== hw/rtl/miller_rabin_prime_test_top_macros.svh =====
// ----------------------------------------------------------------------------
// Miller-Rabin prime test assertion macros
// Shorthand for the concurrent checks on the top level ports.
// ----------------------------------------------------------------------------
`ifndef MILLER_RABIN_PRIME_TEST_TOP_MACROS_SVH
`define MILLER_RABIN_PRIME_TEST_TOP_MACROS_SVH

// same-cycle implication, off while in reset
`define MRPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define MRPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds through reset
`define MRPT_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mrpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin prime test package
// Shared types, witness tables and size thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

package mrpt_pkg;

  localparam int NUM_BITS_DEF = 64;

  // size limits that pick the witness set
  localparam logic [63:0] LIM_0 = 64'd1373653;
  localparam logic [63:0] LIM_1 = 64'd9080191;
  localparam logic [63:0] LIM_2 = 64'd4759123141;
  localparam logic [63:0] LIM_3 = 64'd1122004669633;
  localparam logic [63:0] LIM_4 = 64'd2152302898747;
  localparam logic [63:0] LIM_5 = 64'd3474749660383;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [2:0] wit_class(input logic [63:0] n);
    logic [2:0] cls;
    if (n < LIM_0) cls = 3'd0;
    else if (n < LIM_1) cls = 3'd1;
    else if (n < LIM_2) cls = 3'd2;
    else if (n < LIM_3) cls = 3'd3;
    else if (n < LIM_4) cls = 3'd4;
    else if (n < LIM_5) cls = 3'd5;
    else cls = 3'd6;
    return cls;
  endfunction

  function automatic logic [2:0] wit_count(input logic [2:0] cls);
    logic [2:0] cnt;
    case (cls)
      3'd0: cnt = 3'd2;
      3'd1: cnt = 3'd2;
      3'd2: cnt = 3'd3;
      3'd3: cnt = 3'd4;
      3'd4: cnt = 3'd5;
      3'd5: cnt = 3'd6;
      default: cnt = 3'd7;
    endcase
    return cnt;
  endfunction

  function automatic logic [63:0] wit_value(input logic [2:0] cls, input logic [2:0] idx);
    logic [63:0] w;
    w = 64'd2;
    case (cls)
      3'd0: begin
        case (idx)
          3'd0: w = 64'd2;
          default: w = 64'd3;
        endcase
      end
      3'd1: begin
        case (idx)
          3'd0: w = 64'd31;
          default: w = 64'd73;
        endcase
      end
      3'd2: begin
        case (idx)
          3'd0: w = 64'd2;
          3'd1: w = 64'd7;
          default: w = 64'd61;
        endcase
      end
      3'd3: begin
        case (idx)
          3'd0: w = 64'd2;
          3'd1: w = 64'd13;
          3'd2: w = 64'd23;
          default: w = 64'd1662803;
        endcase
      end
      default: begin
        case (idx)
          3'd0: w = 64'd2;
          3'd1: w = 64'd3;
          3'd2: w = 64'd5;
          3'd3: w = 64'd7;
          3'd4: w = 64'd11;
          3'd5: w = 64'd13;
          default: w = 64'd17;
        endcase
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mrpt_modmul.sv =====
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Shift-add a*b mod m, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module mrpt_modmul import mrpt_pkg::*; #(
  parameter int NUM_BITS = NUM_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [NUM_BITS-1:0] op_a,
  input  wire logic [NUM_BITS-1:0] op_b,
  input  wire logic [NUM_BITS-1:0] modulus,
  output unit_stat_t               stat,
  output logic      [NUM_BITS-1:0] result
);

  localparam int CW = $clog2(NUM_BITS + 1);
  localparam int W  = NUM_BITS + 2;

  logic [NUM_BITS-1:0] a_sh_r, b_r, m_r, acc_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_r, done_r;

  logic [W-1:0]        sum, m1, m2, dif1, dif2;
  logic [NUM_BITS-1:0] acc_nxt;

  // acc < m and b < m keep the sum below 3m
  always_comb begin
    sum  = {1'b0, acc_r, 1'b0} + (a_sh_r[NUM_BITS-1] ? {2'b00, b_r} : '0);
    m1   = {2'b00, m_r};
    m2   = {1'b0, m_r, 1'b0};
    dif1 = sum - m1;
    dif2 = sum - m2;
    if (sum >= m2) acc_nxt = dif2[NUM_BITS-1:0];
    else if (sum >= m1) acc_nxt = dif1[NUM_BITS-1:0];
    else acc_nxt = sum[NUM_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh_r <= op_a;
      b_r    <= op_b;
      m_r    <= modulus;
      acc_r  <= '0;
    end else if (busy_r) begin
      a_sh_r <= a_sh_r << 1;
      acc_r  <= acc_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = acc_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mrpt_mod3.sv =====
// ----------------------------------------------------------------------------
// Bit-serial remainder by three
// Walks the candidate MSB first and keeps a two-bit remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module mrpt_mod3 import mrpt_pkg::*; #(
  parameter int NUM_BITS = NUM_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [NUM_BITS-1:0] value,
  output unit_stat_t               stat,
  output logic                     rem_zero
);

  localparam int CW = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] sh_r;
  logic [1:0]          rem_r, rem_nxt;
  logic [CW-1:0]       cnt_r;
  logic                busy_r, done_r;

  always_comb begin
    case ({rem_r, sh_r[NUM_BITS-1]}) inside
      3'd0, 3'd3: rem_nxt = 2'd0;
      3'd1, 3'd4: rem_nxt = 2'd1;
      3'd2, 3'd5: rem_nxt = 2'd2;
      default:    rem_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= value;
      rem_r <= 2'd0;
    end else if (busy_r) begin
      sh_r  <= sh_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem_zero  = (rem_r == 2'd0);

endmodule

`default_nettype wire

// ===== hw/rtl/miller_rabin_prime_test_top.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin prime test, top level
// Deterministic strong-pseudoprime test of one candidate per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready take one candidate; only its low NUM_BITS bits count.
//   out_valid/out_ready return one is_prime flag per candidate, in order.
//   One candidate is worked on at a time; in_ready is high only while idle.
// Processing:
//   numbers below 2 and even numbers go straight to the output register;
//   otherwise a divide-by-three scan runs first, then per witness a
//   square-and-multiply over the bits of n-1, with each product formed by
//   the bit-serial modular multiplier.
// The result sits in an output register; the next candidate is accepted
// while it waits. If the receiver stalls and a second result is ready, the
// block holds it until the register frees up.
// Reset (synchronous, rst_n low) returns to idle and drops out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module miller_rabin_prime_test_top import mrpt_pkg::*; #(
  parameter int NUM_BITS = NUM_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_candidate,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_is_prime
);

  localparam int CW = $clog2(NUM_BITS + 1);
  localparam logic [NUM_BITS-1:0] ONE = NUM_BITS'(1);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_MOD3  = 10'b0000000010,
    ST_PREP  = 10'b0000000100,
    ST_SKIP  = 10'b0000001000,
    ST_SQ    = 10'b0000010000,
    ST_SQW   = 10'b0000100000,
    ST_ML    = 10'b0001000000,
    ST_MLW   = 10'b0010000000,
    ST_CHECK = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [NUM_BITS-1:0] n_r, n_nxt, nm1_r, nm1_nxt;
  logic [NUM_BITS-1:0] wit_r, wit_nxt, x_r, x_nxt, e_r, e_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [2:0]          cls_r, cls_nxt, widx_r, widx_nxt;
  logic                verdict_r, verdict_nxt;
  logic                out_valid_r, out_valid_nxt, out_prime_r, out_prime_nxt;

  logic [NUM_BITS-1:0] n_in, mm_res;
  logic [63:0]         wit_full;
  logic                mm_start, m3_start, m3_rem_zero;
  unit_stat_t          mm_stat, m3_stat;

  assign n_in     = in_candidate[NUM_BITS-1:0];
  assign wit_full = wit_value(cls_r, widx_r);
  assign mm_start = (state_r == ST_SQ) || (state_r == ST_ML);
  assign m3_start = (state_r == ST_IDLE) && in_valid && (n_in >= NUM_BITS'(2)) && n_in[0];

  mrpt_modmul #(.NUM_BITS(NUM_BITS)) u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start),
    .op_a    (x_r),
    .op_b    ((state_r == ST_ML) ? wit_r : x_r),
    .modulus (n_r),
    .stat    (mm_stat),
    .result  (mm_res)
  );

  mrpt_mod3 #(.NUM_BITS(NUM_BITS)) u_mod3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (m3_start),
    .value    (n_in),
    .stat     (m3_stat),
    .rem_zero (m3_rem_zero)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    nm1_nxt       = nm1_r;
    wit_nxt       = wit_r;
    x_nxt         = x_r;
    e_nxt         = e_r;
    cnt_nxt       = cnt_r;
    cls_nxt       = cls_r;
    widx_nxt      = widx_r;
    verdict_nxt   = verdict_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_prime_nxt = out_prime_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt   = n_in;
          nm1_nxt = n_in - ONE;
          cls_nxt = wit_class(64'(n_in));
          if (n_in < NUM_BITS'(2)) begin
            verdict_nxt = 1'b0;
            state_nxt   = ST_DONE;
          end else if (!n_in[0]) begin
            verdict_nxt = (n_in == NUM_BITS'(2));
            state_nxt   = ST_DONE;
          end else begin
            state_nxt = ST_MOD3;
          end
        end
      end
      ST_MOD3: begin
        if (m3_stat.done) begin
          if (m3_rem_zero) begin
            verdict_nxt = (n_r == NUM_BITS'(3));
            state_nxt   = ST_DONE;
          end else begin
            widx_nxt  = 3'd0;
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        wit_nxt   = wit_full[NUM_BITS-1:0];
        e_nxt     = nm1_r;
        cnt_nxt   = CW'(NUM_BITS);
        state_nxt = ST_SKIP;
      end
      // drop leading zeros of n-1; the top one bit loads x with the witness
      ST_SKIP: begin
        e_nxt   = e_r << 1;
        cnt_nxt = cnt_r - CW'(1);
        if (e_r[NUM_BITS-1]) begin
          x_nxt     = wit_r;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        state_nxt = ST_SQW;
      end
      ST_SQW: begin
        if (mm_stat.done) begin
          x_nxt = mm_res;
          // all remaining exponent bits zero: squaring past a^d
          if ((e_r == '0) && (mm_res == ONE) && (x_r != ONE) && (x_r != nm1_r)) begin
            verdict_nxt = 1'b0;
            state_nxt   = ST_DONE;
          end else if (e_r[NUM_BITS-1]) begin
            state_nxt = ST_ML;
          end else begin
            e_nxt     = e_r << 1;
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = (cnt_r == CW'(1)) ? ST_CHECK : ST_SQ;
          end
        end
      end
      ST_ML: begin
        state_nxt = ST_MLW;
      end
      ST_MLW: begin
        if (mm_stat.done) begin
          x_nxt     = mm_res;
          e_nxt     = e_r << 1;
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = (cnt_r == CW'(1)) ? ST_CHECK : ST_SQ;
        end
      end
      ST_CHECK: begin
        if (x_r != ONE) begin
          verdict_nxt = 1'b0;
          state_nxt   = ST_DONE;
        end else if ((widx_r + 3'd1) == wit_count(cls_r)) begin
          verdict_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          widx_nxt  = widx_r + 3'd1;
          state_nxt = ST_PREP;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = verdict_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    nm1_r       <= nm1_nxt;
    wit_r       <= wit_nxt;
    x_r         <= x_nxt;
    e_r         <= e_nxt;
    cnt_r       <= cnt_nxt;
    cls_r       <= cls_nxt;
    widx_r      <= widx_nxt;
    verdict_r   <= verdict_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_prime_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mrpt_checker.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin prime test port checker
// Watches the top level channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "miller_rabin_prime_test_top_macros.svh"

module mrpt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [63:0] in_candidate,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_is_prime
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready && (in_candidate == in_candidate);

  // a stalled result keeps its flag
  `MRPT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_is_prime), "result dropped or changed while stalled")

  // one candidate at a time: busy right after a transfer
  `MRPT_ASSERT_NXT(a_busy_after_in, in_xfer, !in_ready, "input taken while a candidate is in work")

  // a new result only comes out of a busy period
  `MRPT_ASSERT_NOW(a_out_from_busy, $rose(out_valid), $past(!in_ready), "result appeared without work")

  // reset empties the output register
  `MRPT_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "output valid right after reset")

endmodule

bind miller_rabin_prime_test_top mrpt_checker u_mrpt_checker (.*);

`default_nettype wire

// ===== tb/miller_rabin_prime_test_top_test.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin prime test testbench
// Sends candidates over the valid/ready input channel and checks every
// is_prime verdict, in order, against its table entry or a bit-serial predictor of the test.
// A short table of hand-picked numbers comes first, then random numbers of
// mixed sizes, mostly odd and small so that the run stays short.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module miller_rabin_prime_test_top_test;

  localparam int NBITS = mrpt_pkg::NUM_BITS_DEF;
  localparam int RANDOM_ITEMS = 75;
  localparam int QUIET_FROM = 64;
  localparam int DRAIN_CYCLES = 500;
  localparam int MAX_REPORTS = 10;
  localparam int CYCLE_LIMIT = 40_000_000;
  localparam int DIRECTED_ROWS = 25;

  // bounds that pick the witness set
  localparam bit [63:0] SET0_BELOW = 64'd1373653;
  localparam bit [63:0] SET1_BELOW = 64'd9080191;
  localparam bit [63:0] SET2_BELOW = 64'd4759123141;
  localparam bit [63:0] SET3_BELOW = 64'd1122004669633;
  localparam bit [63:0] SET4_BELOW = 64'd2152302898747;
  localparam bit [63:0] SET5_BELOW = 64'd3474749660383;
  localparam bit [63:0] SPSP_ALL_BASES = 64'd341550071728321;

  typedef struct packed {
    bit [63:0] cand;
    bit        typed;
    bit        verdict;
  } stim_row_t;

  typedef struct packed {
    bit [63:0] cand;
    bit        verdict;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [63:0] in_candidate = '0;
  logic        out_ready = 1'b0;
  wire         in_ready;
  wire         out_valid;
  wire         out_is_prime;

  verdict_t pending_verdicts[$];
  verdict_t oldest;
  bit       quiet_tail = 1'b0;
  int       fail_count = 0;
  int       items_sent = 0;
  int       verdicts_checked = 0;
  int       primes_seen = 0;
  int       cycles = 0;

  // rows with typed = 0 take their verdict from the predictor
  stim_row_t stim_rows [DIRECTED_ROWS] = '{
    '{64'd0, 1'b1, 1'b0},
    '{64'd1, 1'b1, 1'b0},
    '{64'd2, 1'b1, 1'b1},
    '{64'd3, 1'b1, 1'b1},
    '{64'd4, 1'b1, 1'b0},
    '{64'd9, 1'b1, 1'b0},
    '{64'd5, 1'b0, 1'b0},
    '{64'd7, 1'b0, 1'b0},
    '{64'd25, 1'b0, 1'b0},
    '{64'd1729, 1'b0, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0},
    '{64'h8000_0000_0000_0000, 1'b1, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFC5, 1'b0, 1'b0},
    '{64'h1FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
    '{64'd1373653, 1'b0, 1'b0},
    '{64'd1373651, 1'b0, 1'b0},
    '{64'd9080191, 1'b0, 1'b0},
    '{64'd4759123141, 1'b0, 1'b0},
    '{64'd1122004669633, 1'b0, 1'b0},
    '{64'd2152302898747, 1'b0, 1'b0},
    '{64'd3474749660383, 1'b0, 1'b0},
    '{64'd341550071728321, 1'b0, 1'b0},
    '{64'd3215031751, 1'b0, 1'b0},
    '{64'd1662803, 1'b0, 1'b0}
  };

  miller_rabin_prime_test_top #(.NUM_BITS(NBITS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_candidate (in_candidate),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_is_prime (out_is_prime)
  );

  always #2 clk = ~clk;

  function automatic bit [63:0] width_mask(int w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // shift-add product mod m, one multiplier bit per step from the top
  function automatic bit [63:0] mod_mul(bit [63:0] a, bit [63:0] b, bit [63:0] m);
    bit [63:0] acc;
    bit [63:0] half;
    bit [63:0] top;
    acc = '0;
    half = m >> 1;
    top = 64'd1 << (NBITS - 1);
    if (a >= m) a = a % m;
    if (b >= m) b = b % m;
    for (int i = 0; i < NBITS; i++) begin
      acc = (acc > half) ? (acc << 1) - m : (acc << 1);
      if (acc >= m) acc = acc - m;
      if ((a & top) != 0) begin
        if (acc >= m - b) acc = acc - (m - b);
        else acc = acc + b;
      end
      a = a << 1;
    end
    return acc;
  endfunction

  function automatic bit [63:0] mod_pow(bit [63:0] base, bit [63:0] e, bit [63:0] m);
    bit [63:0] r;
    r = (m == 64'd1) ? 64'd0 : 64'd1;
    while (e > 0) begin
      if (e[0]) r = mod_mul(r, base, m);
      e = e >> 1;
      base = mod_mul(base, base, m);
    end
    return r;
  endfunction

  function automatic bit witness_passes(bit [63:0] n, int s, bit [63:0] d, bit [63:0] a);
    bit [63:0] x;
    bit [63:0] y;
    x = mod_pow(a, d, n);
    y = x;
    for (int k = 0; k < s; k++) begin
      y = mod_mul(x, x, n);
      // nontrivial square root of one
      if (y == 64'd1 && x != 64'd1 && x != n - 64'd1) return 1'b0;
      x = y;
    end
    return y == 64'd1;
  endfunction

  function automatic int witness_class(bit [63:0] n);
    if (n < SET0_BELOW) return 0;
    if (n < SET1_BELOW) return 1;
    if (n < SET2_BELOW) return 2;
    if (n < SET3_BELOW) return 3;
    if (n < SET4_BELOW) return 4;
    if (n < SET5_BELOW) return 5;
    return 6;
  endfunction

  function automatic int witness_count(int cls);
    case (cls)
      0, 1: return 2;
      2: return 3;
      3: return 4;
      4: return 5;
      5: return 6;
      default: return 7;
    endcase
  endfunction

  function automatic bit [63:0] witness_of(int cls, int idx);
    case (cls)
      0: return (idx == 0) ? 64'd2 : 64'd3;
      1: return (idx == 0) ? 64'd31 : 64'd73;
      2: begin
        case (idx)
          0: return 64'd2;
          1: return 64'd7;
          default: return 64'd61;
        endcase
      end
      3: begin
        case (idx)
          0: return 64'd2;
          1: return 64'd13;
          2: return 64'd23;
          default: return 64'd1662803;
        endcase
      end
      default: begin
        case (idx)
          0: return 64'd2;
          1: return 64'd3;
          2: return 64'd5;
          3: return 64'd7;
          4: return 64'd11;
          5: return 64'd13;
          default: return 64'd17;
        endcase
      end
    endcase
  endfunction

  function automatic bit primality_verdict(bit [63:0] raw);
    bit [63:0] n;
    bit [63:0] d;
    int        s;
    int        cls;
    n = raw & width_mask(NBITS);
    if (n < 64'd2) return 1'b0;
    if (!n[0]) return n == 64'd2;
    if (n % 64'd3 == 0) return n == 64'd3;
    d = n >> 1;
    s = 1;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    cls = witness_class(n);
    for (int i = 0; i < witness_count(cls); i++) begin
      if (!witness_passes(n, s, d, witness_of(cls, i))) return 1'b0;
    end
    return 1'b1;
  endfunction

  // nearest prime at or below the start with its low bit set
  function automatic bit [63:0] prime_at_or_below(bit [63:0] v);
    v = v | 64'd1;
    while (!primality_verdict(v)) v = v - 64'd2;
    return v;
  endfunction

  task automatic report_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // hold the candidate until its transfer, then log the verdict it owes
  task automatic offer_candidate(bit [63:0] cand, bit verdict);
    verdict_t entry;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      in_candidate <= rand64();
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_candidate <= cand;
    do @(posedge clk); while (!in_ready);
    entry.cand = cand & width_mask(NBITS);
    entry.verdict = verdict;
    pending_verdicts.push_back(entry);
    items_sent++;
  endtask

  // receiver stalls in short bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        report_failure($sformatf("unexpected verdict %0b with no candidate outstanding",
                                 out_is_prime));
      end else begin
        oldest = pending_verdicts.pop_front();
        verdicts_checked++;
        if (out_is_prime !== oldest.verdict) begin
          report_failure($sformatf("verdict mismatch for %0d: expected %0b, got %0b",
                                   oldest.cand, oldest.verdict, out_is_prime));
        end else if (oldest.verdict) begin
          primes_seen++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("miller_rabin_prime_test_top verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    bit [63:0] v;
    int        pick;
    int        w;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      offer_candidate(stim_rows[i].cand,
                      stim_rows[i].typed ? stim_rows[i].verdict
                                         : primality_verdict(stim_rows[i].cand));
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= QUIET_FROM) quiet_tail = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // cases settled without any witness, plus a fully random value
        case ($urandom_range(0, 3))
          0: v = rand64() & ~64'd1;
          1: v = (rand64() >> 2) * 64'd3;
          2: v = 64'($urandom_range(0, 3));
          default: v = rand64();
        endcase
      end else if (pick < 35) begin
        v = rand64() | 64'd1;
      end else if (pick < 60) begin
        w = $urandom_range(3, 34);
        v = (rand64() & width_mask(w)) | (64'd1 << (w - 1)) | 64'd1;
      end else if (pick < 78) begin
        w = $urandom_range(3, 40);
        v = prime_at_or_below((rand64() & width_mask(w)) | (64'd1 << (w - 1)));
      end else if (pick < 88) begin
        // odd numbers around the witness set bounds
        case ($urandom_range(0, 6))
          0: v = SET0_BELOW;
          1: v = SET1_BELOW;
          2: v = SET2_BELOW;
          3: v = SET3_BELOW;
          4: v = SET4_BELOW;
          5: v = SET5_BELOW;
          default: v = SPSP_ALL_BASES;
        endcase
        v = (v + 64'($urandom_range(0, 64)) - 64'd32) | 64'd1;
      end else if (pick < 96) begin
        // carmichael numbers and strong pseudoprimes to small bases
        case ($urandom_range(0, 13))
          0: v = 64'd1105;
          1: v = 64'd1729;
          2: v = 64'd2465;
          3: v = 64'd2821;
          4: v = 64'd6601;
          5: v = 64'd8911;
          6: v = 64'd2047;
          7: v = 64'd3277;
          8: v = 64'd4033;
          9: v = 64'd4681;
          10: v = 64'd8321;
          11: v = 64'd25326001;
          12: v = 64'd3215031751;
          default: v = 64'd2152302898747;
        endcase
      end else begin
        w = $urandom_range(41, 64);
        v = prime_at_or_below((rand64() & width_mask(w)) | (64'd1 << (w - 1)));
      end
      offer_candidate(v, primality_verdict(v));
    end
    in_valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      report_failure($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
    end

    $display("sent %0d candidates (%0d table rows, %0d random) over %0d cycles",
             items_sent, DIRECTED_ROWS, RANDOM_ITEMS, cycles);
    $display("checked %0d verdicts, %0d primes, %0d failures",
             verdicts_checked, primes_seen, fail_count);
    if (fail_count == 0) begin
      $display("miller_rabin_prime_test_top verification clean");
    end else begin
      $display("miller_rabin_prime_test_top verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mrpt_pkg.sv
hw/rtl/mrpt_modmul.sv
hw/rtl/mrpt_mod3.sv
hw/rtl/miller_rabin_prime_test_top.sv
hw/rtl/mrpt_checker.sv
tb/miller_rabin_prime_test_top_test.sv
